// File: hdl/epfc_pkg.sv
// ---------------------------------------------------------------------------
// Packet framer package
// Shared types, queue sizing and byte-sequence step codes for the framer.
// ---------------------------------------------------------------------------
package epfc_pkg;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Header fields carried per command (remote_addr .. ack_number)
  localparam int unsigned NumFields  = 6;
  localparam int unsigned FieldRemoteAddr = 0;
  localparam int unsigned FieldLocalAddr  = 2;
  localparam int unsigned FieldDataWord   = 0;

  // Byte step codes on the output sequence
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepFirst    = 5'd0;
  localparam logic [StepW-1:0] StepDataLast = 5'd1;
  localparam logic [StepW-1:0] StepHdrWord  = 5'd4;   // first summed header byte
  localparam logic [StepW-1:0] StepHdrLast  = 5'd19;
  localparam logic [StepW-1:0] StepTrlFirst = 5'd20;
  localparam logic [StepW-1:0] StepCkHigh   = 5'd24;
  localparam logic [StepW-1:0] StepTrlLast  = 5'd25;

  // Input item modes
  localparam logic ModeHeader = 1'b0;
  localparam logic ModeData   = 1'b1;

  typedef enum logic {
    ITEM_HDR  = 1'b0,
    ITEM_DATA = 1'b1
  } item_kind_e;

  // One queued command: header or data word
  typedef struct packed {
    item_kind_e                   kind;
    logic                         last;     // trailer follows this item
    logic [7:0]                   opcode;
    logic [11:0]                  length;
    logic [NumFields-1:0][15:0]   field;    // data word sits in field 0
  } cmd_t;

  // Handshake between a producer and the queue / queue and consumer
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Ones' complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s[15:0]} + {16'h0000, s[16]};
    return t[15:0];
  endfunction

endpackage

// File: hdl/epfc_in_if.sv
// ---------------------------------------------------------------------------
// Framer input channel
// Valid/ready channel carrying one header or data item per transaction.
// ---------------------------------------------------------------------------
interface epfc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  opcode;
  logic [11:0] length;
  logic [15:0] remote_addr;
  logic [15:0] remote_index;
  logic [15:0] local_addr;
  logic [15:0] local_index;
  logic [15:0] packet_number;
  logic [15:0] ack_number;
  logic [15:0] data_word;

  modport source (
    output valid, mode, opcode, length, remote_addr, remote_index, local_addr,
           local_index, packet_number, ack_number, data_word,
    input  ready
  );
  modport sink (
    input  valid, mode, opcode, length, remote_addr, remote_index, local_addr,
           local_index, packet_number, ack_number, data_word,
    output ready
  );
endinterface

// File: hdl/epfc_out_if.sv
// ---------------------------------------------------------------------------
// Framer output channel
// Valid/ready channel carrying one frame byte per transaction.
// ---------------------------------------------------------------------------
interface epfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (
    output valid, out_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, frame_end,
    output ready
  );
endinterface

// File: hdl/encapsulated_packet_framer_checksum_top.sv
// ---------------------------------------------------------------------------
// Encapsulated packet framer with ones' complement checksum
// Front end classifies items, a short command queue decouples it from the
// byte serialiser that builds header, data words and checksum trailer.
//
//   channel | dir | width of payload         | contents
//   in_i    | in  | 1+8+12+6x16+16 bits      | header or data item
//   out_o   | out | 8+1 bits                 | frame byte, frame end flag
//
// The output side moves one byte per cycle while out_o is ready: a header
// gives 20 bytes, a data word 2 and the trailer 6; the single-byte output
// register sets that rate. Items are accepted while the queue has room.
// An accepted item passes through the queue, then the output register.
// Reset is asynchronous, active low, and clears the packet state and queue.
// Either side may stall; the queue absorbs up to two pending commands.
// ---------------------------------------------------------------------------
module encapsulated_packet_framer_checksum_top
  import epfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  epfc_in_if.sink    in_i,
  epfc_out_if.source out_o
);

  cmd_push_t     push;
  cmd_t          head;
  queue_status_t q_status;
  logic          pop;

  // Accept and classify
  epfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push)
  );

  // Command queue
  epfc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Byte serialiser and checksum
  epfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

// File: hdl/epfc_front.sv
// ---------------------------------------------------------------------------
// Framer front end
// Accepts items, tracks the open packet and queues header / data commands.
// Data items with no open packet are dropped here.
// ---------------------------------------------------------------------------
module epfc_front
  import epfc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  epfc_in_if.sink       in_i,
  input  queue_status_t q_status_i,
  output cmd_push_t     push_o
);

  logic        open_q, open_d;
  logic [10:0] words_left_q, words_left_d;
  logic        accept;
  logic [12:0] len_plus;
  logic [11:0] words;

  assign in_i.ready = ~q_status_i.full;
  assign accept     = in_i.valid & in_i.ready;

  // Word count of the packet, an odd byte length rounded up
  assign len_plus = {1'b0, in_i.length} + 13'd1;
  assign words    = len_plus[12:1];

  // Classify the accepted transaction
  always_comb begin
    open_d               = open_q;
    words_left_d         = words_left_q;
    push_o.valid         = 1'b0;
    push_o.cmd.kind      = ITEM_HDR;
    push_o.cmd.last      = 1'b0;
    push_o.cmd.opcode    = in_i.opcode;
    push_o.cmd.length    = in_i.length;
    push_o.cmd.field     = {in_i.ack_number, in_i.packet_number, in_i.local_index,
                            in_i.local_addr, in_i.remote_index, in_i.remote_addr};
    if (accept) begin
      if (in_i.mode == ModeHeader) begin
        push_o.valid    = 1'b1;
        push_o.cmd.last = (in_i.length == 12'd0);
        open_d          = (in_i.length != 12'd0);
        words_left_d    = 11'(words - 12'd1);
      end else if (open_q) begin
        push_o.valid                   = 1'b1;
        push_o.cmd.kind                = ITEM_DATA;
        push_o.cmd.last                = (words_left_q == 11'd0);
        push_o.cmd.field[FieldDataWord] = in_i.data_word;
        if (words_left_q == 11'd0) begin
          open_d = 1'b0;
        end else begin
          words_left_d = words_left_q - 11'd1;
        end
      end
    end
  end

  // Packet tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      words_left_q <= '0;
    end else begin
      open_q       <= open_d;
      words_left_q <= words_left_d;
    end
  end

endmodule

// File: hdl/epfc_queue.sv
// ---------------------------------------------------------------------------
// Framer command queue
// Short register FIFO decoupling the front end from the byte serialiser.
// ---------------------------------------------------------------------------
module epfc_queue
  import epfc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_push_t     push_i,
  input  logic          pop_i,
  output cmd_t          head_o,
  output queue_status_t status_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i.valid & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // Pointer wrap at the queue depth
  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    logic [QueuePtrW-1:0] r;
    if (p == QueuePtrW'(QueueDepth - 1)) r = '0;
    else                                 r = p + QueuePtrW'(1);
    return r;
  endfunction

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + QueueCntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - QueueCntW'(1);
    end
  end

endmodule

// File: hdl/epfc_back.sv
// ---------------------------------------------------------------------------
// Framer back end
// Serialises queued commands into frame bytes, keeps the running checksum
// and appends the trailer (addresses and inverted sum) after the last item.
// ---------------------------------------------------------------------------
module epfc_back
  import epfc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          head_i,
  input  queue_status_t q_status_i,
  output logic          pop_o,
  epfc_out_if.source    out_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      held_remote_q, held_local_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             frame_end_q;

  logic             load;
  logic             in_trailer;
  logic [StepW-1:0] trl_off;
  logic [2:0]       hdr_idx;
  logic [15:0]      cur_word;
  logic [7:0]       cur_byte;
  logic             add_en;

  assign load       = ~q_status_i.empty & (~out_valid_q | out_o.ready);
  assign in_trailer = (step_q >= StepTrlFirst);
  assign trl_off    = step_q - StepTrlFirst;
  assign hdr_idx    = 3'(step_q[StepW-1:1] - 4'd2);

  // Word holding the current byte
  always_comb begin
    cur_word = 16'h0000;
    if (in_trailer) begin
      case (trl_off[2:1])
        2'd0:    cur_word = held_remote_q;
        2'd1:    cur_word = held_local_q;
        default: cur_word = ~sum_q;
      endcase
    end else if (head_i.kind == ITEM_DATA) begin
      cur_word = head_i.field[FieldDataWord];
    end else if (step_q < StepHdrWord) begin
      cur_word = (step_q < 5'd2) ? 16'h0101 : 16'h0000;
    end else begin
      case (hdr_idx)
        3'd0:    cur_word = {head_i.opcode, 8'h00};
        3'd1:    cur_word = {4'h0, head_i.length};
        default: cur_word = head_i.field[3'(hdr_idx - 3'd2)];
      endcase
    end
  end

  assign cur_byte = step_q[0] ? cur_word[7:0] : cur_word[15:8];

  // Summed words end on odd steps: header byte 4 to local address, and data words
  assign add_en = step_q[0] && (step_q < StepCkHigh) &&
                  ((step_q > StepHdrWord) || (head_i.kind == ITEM_DATA));

  // Step sequencing and queue pop
  always_comb begin
    step_d = step_q;
    pop_o  = 1'b0;
    if (load) begin
      if (in_trailer) begin
        if (step_q == StepTrlLast) begin
          step_d = StepFirst;
          pop_o  = 1'b1;
        end else begin
          step_d = step_q + 5'd1;
        end
      end else if ((head_i.kind == ITEM_DATA && step_q == StepDataLast) ||
                   (head_i.kind == ITEM_HDR  && step_q == StepHdrLast)) begin
        if (head_i.last) begin
          step_d = StepTrlFirst;
        end else begin
          step_d = StepFirst;
          pop_o  = 1'b1;
        end
      end else begin
        step_d = step_q + 5'd1;
      end
    end
  end

  // Running checksum
  always_comb begin
    sum_d = sum_q;
    if (load) begin
      if (head_i.kind == ITEM_HDR && step_q == StepFirst) begin
        sum_d = 16'h0000;
      end else if (add_en) begin
        sum_d = oc_add(sum_q, cur_word);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepFirst;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // Output register, checksum and held trailer addresses
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (load) begin
      out_byte_q  <= cur_byte;
      frame_end_q <= in_trailer && (step_q == StepTrlLast);
      if (head_i.kind == ITEM_HDR && step_q == StepFirst) begin
        held_remote_q <= head_i.field[FieldRemoteAddr];
        held_local_q  <= head_i.field[FieldLocalAddr];
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.frame_end = frame_end_q;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packet framer testbench
// Sends header and data items into the framer and checks every output byte
// against a framing model kept in the bench: header bytes, data words, the
// address trailer and the ones' complement checksum. A short directed table
// comes first, then random packets, abandoned packets and stray data items,
// with random stalls on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;
  import epfc_pkg::*;

  localparam int unsigned NumItems   = 170;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned FrameBytes = 26;

  // One input item, with an optional hand-written frame for the directed rows
  typedef struct packed {
    logic         mode;
    logic [7:0]   opcode;
    logic [11:0]  length;
    logic [15:0]  raddr;
    logic [15:0]  rindex;
    logic [15:0]  laddr;
    logic [15:0]  lindex;
    logic [15:0]  pkt_num;
    logic [15:0]  ack_num;
    logic [15:0]  data_word;
    logic         typed;
    logic [4:0]   typed_n;
    logic [207:0] typed_bytes;
  } framer_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  logic clk_i;
  logic rst_ni;

  epfc_in_if  in_bus ();
  epfc_out_if out_bus ();

  encapsulated_packet_framer_checksum_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Clock and reset
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Framing model state
  logic        pkt_open;
  logic [10:0] words_due;
  logic [15:0] csum;
  logic [15:0] held_raddr;
  logic [15:0] held_laddr;

  frame_byte_t  frame_q[$];
  framer_item_t stim_q[$];
  int unsigned  mismatch_count;
  int unsigned  sent_idx;
  bit           calm;
  bit           stim_done;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic [15:0] oc_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[15:0] + {15'd0, wide[16]};
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic last);
    frame_byte_t fb;
    fb.value = value;
    fb.last  = last;
    frame_q.push_back(fb);
  endtask

  // Big-endian word that also goes into the checksum
  task automatic emit_summed(input logic [15:0] w);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], 1'b0);
    csum = oc_sum(csum, w);
  endtask

  task automatic close_frame();
    logic [15:0] ck;
    emit_summed(held_raddr);
    emit_summed(held_laddr);
    ck = ~csum;
    push_byte(ck[15:8], 1'b0);
    push_byte(ck[7:0], 1'b1);
    pkt_open  = 1'b0;
    words_due = '0;
    csum      = '0;
  endtask

  // Expected bytes for one accepted item
  task automatic frame_item(input framer_item_t it);
    int unsigned base;
    logic [12:0] words;
    base = frame_q.size();
    if (it.mode == ModeHeader) begin
      held_raddr = it.raddr;
      held_laddr = it.laddr;
      csum       = '0;
      push_byte(8'h01, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      emit_summed({it.opcode, 8'h00});
      emit_summed({4'h0, it.length});
      emit_summed(it.raddr);
      emit_summed(it.rindex);
      emit_summed(it.laddr);
      emit_summed(it.lindex);
      emit_summed(it.pkt_num);
      emit_summed(it.ack_num);
      words = ({1'b0, it.length} + 13'd1) >> 1;
      if (words == '0) begin
        close_frame();
      end else begin
        pkt_open  = 1'b1;
        words_due = 11'(words - 13'd1);
      end
    end else if (pkt_open) begin
      emit_summed(it.data_word);
      if (words_due == '0) begin
        close_frame();
      end else begin
        words_due = words_due - 11'd1;
      end
    end
    // Hand-written rows replace the computed bytes
    if (it.typed) begin
      while (frame_q.size() > base) void'(frame_q.pop_back());
      for (int k = 0; k < int'(it.typed_n); k++) begin
        push_byte(it.typed_bytes[207 - 8 * k -: 8], k == FrameBytes - 1);
      end
    end
  endtask

  function automatic framer_item_t hdr_item(input logic [7:0] op, input logic [11:0] len,
                                            input logic [15:0] ra, input logic [15:0] ri,
                                            input logic [15:0] la, input logic [15:0] li,
                                            input logic [15:0] pn, input logic [15:0] an);
    framer_item_t it;
    it         = '0;
    it.mode    = ModeHeader;
    it.opcode  = op;
    it.length  = len;
    it.raddr   = ra;
    it.rindex  = ri;
    it.laddr   = la;
    it.lindex  = li;
    it.pkt_num = pn;
    it.ack_num = an;
    return it;
  endfunction

  function automatic framer_item_t data_item(input logic [15:0] w);
    framer_item_t it;
    it           = '0;
    it.mode      = ModeData;
    it.data_word = w;
    return it;
  endfunction

  function automatic framer_item_t with_frame(input framer_item_t it, input logic [4:0] n,
                                              input logic [207:0] bytes);
    framer_item_t r;
    r             = it;
    r.typed       = 1'b1;
    r.typed_n     = n;
    r.typed_bytes = bytes;
    return r;
  endfunction

  // Random header; unused data word gets noise too
  function automatic framer_item_t rand_hdr(input logic [11:0] len);
    framer_item_t it;
    it = hdr_item(8'($urandom()), len, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), 16'($urandom()));
    it.data_word = 16'($urandom());
    return it;
  endfunction

  // Random data word; header fields carry noise the block must ignore
  function automatic framer_item_t rand_data();
    framer_item_t it;
    it = rand_hdr(12'($urandom()));
    it.mode = ModeData;
    return it;
  endfunction

  // Stimulus build: directed table, then random traffic
  task automatic build_stimulus();
    framer_item_t tbl[23];
    int unsigned  counted;
    int unsigned  pick;
    int unsigned  len;
    tbl[0]  = with_frame(data_item(16'hFFFF), 5'd0, '0);
    tbl[1]  = with_frame(hdr_item(8'h00, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0),
                         5'd26,
                         208'h0101_0000_0000_0000_0000_0000_0000_0000_0000_0000_0000_0000_FFFF);
    tbl[2]  = with_frame(hdr_item(8'hFF, 12'h000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF),
                         5'd26,
                         208'h0101_0000_FF00_0000_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_00FF);
    tbl[3]  = with_frame(data_item(16'h0000), 5'd0, '0);
    tbl[4]  = hdr_item(8'h5A, 12'd1, 16'h1234, 16'h0001, 16'h4321, 16'h0002, 16'h0010, 16'h0020);
    tbl[5]  = data_item(16'hFFFF);
    tbl[6]  = hdr_item(8'h80, 12'd2, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h00FF, 16'hFF00);
    tbl[7]  = data_item(16'h0000);
    tbl[8]  = hdr_item(8'h3C, 12'hFFF, 16'hA5A5, 16'h5A5A, 16'hC3C3, 16'h3C3C, 16'h0F0F, 16'hF0F0);
    tbl[9]  = data_item(16'hA55A);
    tbl[10] = data_item(16'h5AA5);
    tbl[11] = hdr_item(8'hFF, 12'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    tbl[12] = data_item(16'hFFFF);
    tbl[13] = data_item(16'hFFFF);
    tbl[14] = hdr_item(8'h00, 12'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tbl[15] = data_item(16'h8001);
    tbl[16] = data_item(16'h7FFE);
    tbl[17] = hdr_item(8'h11, 12'h800, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 16'h090A, 16'h0B0C);
    tbl[18] = hdr_item(8'h42, 12'd5, 16'hBEEF, 16'h0042, 16'hCAFE, 16'h0007, 16'h1000, 16'h2000);
    tbl[19] = data_item(16'h0001);
    tbl[20] = data_item(16'h0002);
    tbl[21] = data_item(16'h0003);
    tbl[22] = data_item(16'hDEAD);
    foreach (tbl[i]) stim_q.push_back(tbl[i]);

    // Random part: mostly whole packets, some abandoned ones and strays
    counted = stim_q.size();
    while (counted < NumItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        stim_q.push_back(rand_hdr(12'(len)));
        counted++;
        for (int w = 0; w < int'((len + 1) / 2); w++) begin
          stim_q.push_back(rand_data());
          counted++;
        end
      end else if (pick < 82) begin
        stim_q.push_back(rand_hdr(12'($urandom())));
        counted++;
        for (int w = 0; w < int'($urandom_range(0, 3)); w++) begin
          stim_q.push_back(rand_data());
          counted++;
        end
      end else if (pick < 92) begin
        for (int w = 0; w < int'($urandom_range(1, 2)); w++) stim_q.push_back(rand_data());
      end else begin
        stim_q.push_back(rand_hdr(12'd0));
        counted++;
      end
    end
  endtask

  task automatic drive_item(input framer_item_t it);
    in_bus.mode          <= it.mode;
    in_bus.opcode        <= it.opcode;
    in_bus.length        <= it.length;
    in_bus.remote_addr   <= it.raddr;
    in_bus.remote_index  <= it.rindex;
    in_bus.local_addr    <= it.laddr;
    in_bus.local_index   <= it.lindex;
    in_bus.packet_number <= it.pkt_num;
    in_bus.ack_number    <= it.ack_num;
    in_bus.data_word     <= it.data_word;
  endtask

  // Sender: offers items, predicts each one as its transaction completes
  initial begin
    framer_item_t cur;
    bit           pending;
    cur        = '0;
    pending    = 1'b0;
    pkt_open   = 1'b0;
    words_due  = '0;
    csum       = '0;
    held_raddr = '0;
    held_laddr = '0;
    sent_idx   = 0;
    calm       = 1'b0;
    stim_done  = 1'b0;
    in_bus.valid <= 1'b0;
    drive_item(cur);
    build_stimulus();
    @(posedge rst_ni);
    while (sent_idx < stim_q.size() || pending) begin
      @(posedge clk_i);
      if (in_bus.valid && in_bus.ready) begin
        frame_item(cur);
        pending = 1'b0;
      end
      if (!in_bus.valid || in_bus.ready) begin
        calm = (sent_idx >= 100) && (sent_idx < 145);
        if (sent_idx < stim_q.size() && (calm || $urandom_range(0, 99) >= 36)) begin
          cur = stim_q[sent_idx];
          sent_idx++;
          drive_item(cur);
          in_bus.valid <= 1'b1;
          pending = 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
    stim_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off to back the framer up
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_idx >= 40) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  // Output check against the oldest expected byte
  always @(posedge clk_i) begin
    frame_byte_t exp_b;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (frame_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_bus.out_byte));
      end else begin
        exp_b = frame_q.pop_front();
        if (out_bus.out_byte !== exp_b.value)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_bus.out_byte, exp_b.value));
        if (out_bus.frame_end !== exp_b.last)
          report_mismatch($sformatf("frame_end %0b, expected %0b",
                                    out_bus.frame_end, exp_b.last));
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d idle cycles, %0d bytes outstanding", IdleLimit, frame_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // End of run
  initial begin
    mismatch_count = 0;
    @(posedge rst_ni);
    while (!stim_done || frame_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
